// ----- design/nth_pkg.sv -----
// Package for the name timestamp hash table: sizes, codes, state encoding
// and the command/status bundles passed between controller and datapath.
// No dependencies.
package nth_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int NAME_BYTES  = 52;
  localparam int MAX_NAME    = NAME_BYTES - 1;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int LEN_W  = $clog2(NAME_BYTES);
  localparam int OCC_W  = SLOT_W + 1;
  localparam int ADDR_W = $clog2(TABLE_SLOTS * NAME_BYTES);

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_TOO_LONG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_EVAL,
    S_CMP_RD,
    S_CMP_CHK,
    S_RESOLVE,
    S_COPY_RD,
    S_COPY_WR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_byte;
    logic    next_slot;
    logic    byte_clear;
    logic    byte_next;
    logic    insert;
    logic    stamp;
    logic    copy_wr;
    logic    clear_key;
    logic    emit;
    logic    use_slot_stamp;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf;
    logic slot_valid;
    logic meta_eq;
    logic len_zero;
    logic byte_eq;
    logic byte_last;
    logic probe_last;
    logic full;
  } sts_t;

endpackage

// ----- design/nth_ctrl.sv -----
// Controller state machine of the name timestamp hash table.
// Depends on nth_pkg for the state encoding and the command/status types.
module nth_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          action_i,
  input  logic          last_byte_i,
  input  nth_pkg::sts_t sts_i,
  output nth_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import nth_pkg::*;

  state_e state_q, state_d;
  logic   found_q, found_d;
  logic   action_q;

  // State, match flag and action registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      found_q  <= 1'b0;
      action_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (state_q == S_IDLE && start_i && last_byte_i) begin
        action_q <= action_i;
      end
    end
  end

  // Next state logic.
  always_comb begin
    state_d = state_q;
    found_d = found_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && last_byte_i) begin
          state_d = S_META;
        end
      end
      S_META: begin
        state_d = sts_i.ovf ? S_IDLE : S_EVAL;
      end
      S_EVAL: begin
        if (!sts_i.slot_valid) begin
          found_d = 1'b0;
          state_d = S_RESOLVE;
        end else if (sts_i.meta_eq && sts_i.len_zero) begin
          found_d = 1'b1;
          state_d = S_RESOLVE;
        end else if (sts_i.meta_eq) begin
          state_d = S_CMP_RD;
        end else if (sts_i.probe_last) begin
          found_d = 1'b0;
          state_d = S_RESOLVE;
        end else begin
          state_d = S_META;
        end
      end
      S_CMP_RD: begin
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (sts_i.byte_eq && sts_i.byte_last) begin
          found_d = 1'b1;
          state_d = S_RESOLVE;
        end else if (sts_i.byte_eq) begin
          state_d = S_CMP_RD;
        end else if (sts_i.probe_last) begin
          found_d = 1'b0;
          state_d = S_RESOLVE;
        end else begin
          state_d = S_META;
        end
      end
      S_RESOLVE: begin
        if (action_q && !found_q && !(sts_i.full || sts_i.slot_valid) && !sts_i.len_zero) begin
          state_d = S_COPY_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        state_d = sts_i.byte_last ? S_IDLE : S_COPY_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.status = STAT_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_byte = start_i;
      end
      S_META: begin
        if (sts_i.ovf) begin
          cmd_o.emit      = 1'b1;
          cmd_o.status    = STAT_TOO_LONG;
          cmd_o.clear_key = 1'b1;
        end
      end
      S_EVAL: begin
        if (sts_i.slot_valid && sts_i.meta_eq && !sts_i.len_zero) begin
          cmd_o.byte_clear = 1'b1;
        end else if (sts_i.slot_valid && !sts_i.meta_eq) begin
          cmd_o.next_slot = 1'b1;
        end
      end
      S_CMP_RD: begin
        cmd_o = '0;
      end
      S_CMP_CHK: begin
        if (sts_i.byte_eq && !sts_i.byte_last) begin
          cmd_o.byte_next = 1'b1;
        end else if (!sts_i.byte_eq) begin
          cmd_o.next_slot = 1'b1;
        end
      end
      S_RESOLVE: begin
        cmd_o.emit = 1'b1;
        if (!action_q) begin
          cmd_o.status         = found_q ? STAT_OK : STAT_NOT_FOUND;
          cmd_o.use_slot_stamp = found_q;
          cmd_o.clear_key      = 1'b1;
        end else if (!found_q && (sts_i.full || sts_i.slot_valid)) begin
          cmd_o.status    = STAT_FULL;
          cmd_o.clear_key = 1'b1;
        end else begin
          cmd_o.stamp = 1'b1;
          if (!found_q) begin
            cmd_o.insert     = 1'b1;
            cmd_o.byte_clear = 1'b1;
            cmd_o.clear_key  = sts_i.len_zero;
          end else begin
            cmd_o.clear_key = 1'b1;
          end
        end
      end
      S_COPY_RD: begin
        cmd_o = '0;
      end
      S_COPY_WR: begin
        cmd_o.copy_wr   = 1'b1;
        cmd_o.byte_next = !sts_i.byte_last;
        cmd_o.clear_key = sts_i.byte_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- design/nth_dp.sv -----
// Datapath of the name timestamp hash table: hash accumulator, key buffer,
// slot memories, probe counters and result register. Depends on nth_pkg.
module nth_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    name_byte_i,
  input  logic          last_byte_i,
  input  nth_pkg::cmd_t cmd_i,
  output nth_pkg::sts_t sts_o,
  output logic          done_o,
  output logic [31:0]   timestamp_o,
  output logic [1:0]    status_o
);
  import nth_pkg::*;

  // Key accumulator.
  logic [31:0]      hash_q, hash_d;
  logic [LEN_W-1:0] len_q;
  logic             ovf_q;
  logic [7:0]       key_mem [MAX_NAME];
  logic [7:0]       kb_rd_q;

  // Probe position.
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] cnt_q;
  logic [LEN_W-1:0]  bi_q;

  // Table storage.
  logic [TABLE_SLOTS-1:0] valid_q;
  logic [OCC_W-1:0]       occ_q;
  logic [31:0]            counter_q, counter_inc;
  logic [31:0]            hash_mem  [TABLE_SLOTS];
  logic [LEN_W-1:0]       len_mem   [TABLE_SLOTS];
  logic [31:0]            stamp_mem [TABLE_SLOTS];
  logic [7:0]             name_mem  [TABLE_SLOTS * NAME_BYTES];
  logic [31:0]            hash_rd_q, stamp_rd_q;
  logic [LEN_W-1:0]       len_rd_q;
  logic [7:0]             sb_rd_q;
  logic [ADDR_W-1:0]      name_addr;

  // Result register.
  logic        done_q;
  logic [31:0] ts_q;
  logic [1:0]  stat_q;

  // Next hash value for an incoming byte; zero bytes are skipped.
  always_comb begin
    hash_d = hash_q;
    if (name_byte_i != 8'd0) begin
      hash_d = (hash_q << 5) + hash_q + {24'd0, name_byte_i};
    end
  end

  assign counter_inc = (counter_q == 32'hFFFF_FFFF) ? counter_q : counter_q + 32'd1;
  assign name_addr   = ADDR_W'(idx_q) * ADDR_W'(NAME_BYTES) + ADDR_W'(bi_q);

  // Control registers of the key, probe and table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= HASH_SEED;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      bi_q      <= '0;
      valid_q   <= '0;
      occ_q     <= '0;
      counter_q <= '0;
      done_q    <= 1'b0;
      ts_q      <= '0;
      stat_q    <= '0;
    end else begin
      if (cmd_i.load_byte) begin
        hash_q <= hash_d;
        if (name_byte_i != 8'd0) begin
          if (len_q < LEN_W'(MAX_NAME)) begin
            len_q <= len_q + LEN_W'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        if (last_byte_i) begin
          idx_q <= hash_d[SLOT_W-1:0];
          cnt_q <= '0;
        end
      end
      if (cmd_i.next_slot) begin
        idx_q <= idx_q + SLOT_W'(1);
        cnt_q <= cnt_q + SLOT_W'(1);
      end
      if (cmd_i.byte_clear) begin
        bi_q <= '0;
      end else if (cmd_i.byte_next) begin
        bi_q <= bi_q + LEN_W'(1);
      end
      if (cmd_i.insert) begin
        valid_q[idx_q] <= 1'b1;
        occ_q          <= occ_q + OCC_W'(1);
      end
      if (cmd_i.stamp) begin
        counter_q <= counter_inc;
      end
      if (cmd_i.clear_key) begin
        hash_q <= HASH_SEED;
        len_q  <= '0;
        ovf_q  <= 1'b0;
      end
      done_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        stat_q <= cmd_i.status;
        if (cmd_i.stamp) begin
          ts_q <= counter_inc;
        end else if (cmd_i.use_slot_stamp) begin
          ts_q <= stamp_rd_q;
        end else begin
          ts_q <= '0;
        end
      end
    end
  end

  // Key buffer: written while bytes arrive, read one byte a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte && name_byte_i != 8'd0 && len_q < LEN_W'(MAX_NAME)) begin
      key_mem[len_q] <= name_byte_i;
    end
    kb_rd_q <= key_mem[bi_q];
  end

  // Slot metadata memories, read at the current probe slot every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      hash_mem[idx_q] <= hash_q;
      len_mem[idx_q]  <= len_q;
    end
    if (cmd_i.stamp) begin
      stamp_mem[idx_q] <= counter_inc;
    end
    hash_rd_q  <= hash_mem[idx_q];
    len_rd_q   <= len_mem[idx_q];
    stamp_rd_q <= stamp_mem[idx_q];
  end

  // Slot name memory, one byte per access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) begin
      name_mem[name_addr] <= kb_rd_q;
    end
    sb_rd_q <= name_mem[name_addr];
  end

  // Status toward the controller.
  always_comb begin
    sts_o.ovf        = ovf_q;
    sts_o.slot_valid = valid_q[idx_q];
    sts_o.meta_eq    = (hash_rd_q == hash_q) && (len_rd_q == len_q);
    sts_o.len_zero   = (len_q == '0);
    sts_o.byte_eq    = (kb_rd_q == sb_rd_q);
    sts_o.byte_last  = (bi_q == len_q - LEN_W'(1));
    sts_o.probe_last = (cnt_q == SLOT_W'(TABLE_SLOTS - 1));
    sts_o.full       = ({occ_q, 1'b0} > (OCC_W + 1)'(TABLE_SLOTS));
  end

  assign done_o      = done_q;
  assign timestamp_o = ts_q;
  assign status_o    = stat_q;

  // A refused or missing result always carries a zero stamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && stat_q != STAT_OK |-> ts_q == 32'd0)
    else $error("nonzero stamp on a failed transaction");

  // Occupancy never passes half the table plus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TABLE_SLOTS / 2 + 1))
    else $error("table occupancy out of range");

  // An insert only targets a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !valid_q[idx_q])
    else $error("insert into an occupied slot");

  // The stamp counter never decreases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> counter_q >= $past(counter_q))
    else $error("stamp counter went backward");

endmodule

// ----- design/name_timestamp_hash_table.sv -----
// Top level of the name timestamp hash table: controller plus datapath.
// Throughput: bytes are taken one per cycle while busy is low; the last byte starts a probe.
// Per probed slot the FSM passes META and EVAL, per compared byte CMP_RD and CMP_CHK; done_o
// is registered from RESOLVE, or from META for a too-long name. An insert keeps busy high
// while COPY_RD/COPY_WR copy the name. The receiver cannot stall; results are one-cycle pulses.
// Reset (asynchronous, active low) empties the table and clears the stamp counter.
module name_timestamp_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [7:0]  name_byte_i,
  input  logic        last_byte_i,
  output logic        done_o,
  output logic [31:0] timestamp_o,
  output logic [1:0]  status_o
);
  import nth_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of one name transaction.
  nth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_i),
    .last_byte_i (last_byte_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  // Storage and arithmetic.
  nth_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .name_byte_i (name_byte_i),
    .last_byte_i (last_byte_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .timestamp_o (timestamp_o),
    .status_o    (status_o)
  );

endmodule

// ----- verif/name_timestamp_hash_table_checker.sv -----
// Checker for the name timestamp hash table: watches the byte and result channels,
// predicts each stamp lookup or update and compares field by field.
// Depends on nth_pkg for sizes and status codes.
`timescale 1ns / 100ps

module name_timestamp_hash_table_checker
  import nth_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        action_i,
  input  logic [7:0]  name_byte_i,
  input  logic        last_byte_i,
  input  logic        done_o,
  input  logic [31:0] timestamp_o,
  input  logic [1:0]  status_o,
  output int unsigned err_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [31:0] stamp;
    status_e     status;
  } lookup_result_t;

  // Shadow copy of the key accumulator and the table.
  logic [31:0]    key_hash;
  logic [7:0]     key_buf [NAME_BYTES];
  int unsigned    key_len;
  logic           key_ovf;
  logic           tbl_valid [TABLE_SLOTS];
  logic [31:0]    tbl_hash  [TABLE_SLOTS];
  logic [7:0]     tbl_name  [TABLE_SLOTS][NAME_BYTES];
  logic [31:0]    tbl_stamp [TABLE_SLOTS];
  int unsigned    tbl_used;
  logic [31:0]    stamp_ctr;
  lookup_result_t lookup_q [$];

  // Return the key accumulator to its empty state.
  task automatic clear_name_key();
    key_hash = HASH_SEED;
    key_len  = 0;
    key_ovf  = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) key_buf[i] = 8'h00;
  endtask

  // True when slot s holds exactly the current key.
  function automatic bit slot_holds_key(int unsigned s);
    if (tbl_hash[s] != key_hash) return 1'b0;
    for (int i = 0; i < key_len; i++) begin
      if (tbl_name[s][i] != key_buf[i]) return 1'b0;
    end
    return tbl_name[s][key_len] == 8'h00;
  endfunction

  // Walk the table from the home slot until a match or an empty slot.
  task automatic probe_table(output bit found, output int unsigned where);
    int unsigned s;
    s = key_hash % TABLE_SLOTS;
    found = 1'b0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!tbl_valid[s]) begin
        where = s;
        return;
      end
      if (slot_holds_key(s)) begin
        found = 1'b1;
        where = s;
        return;
      end
      s = (s + 1) % TABLE_SLOTS;
    end
    where = s;
  endtask

  // Fold one accepted byte into the key; a last byte resolves the name.
  task automatic take_name_byte(logic act, logic [7:0] b, logic last);
    bit             found;
    int unsigned    s;
    lookup_result_t r;
    if (b != 8'h00) begin
      key_hash = key_hash * 32'd33 + {24'd0, b};
      if (key_len < MAX_NAME) begin
        key_buf[key_len] = b;
        key_len++;
      end else begin
        key_ovf = 1'b1;
      end
    end
    if (!last) return;
    r.stamp  = '0;
    r.status = STAT_OK;
    if (key_ovf) begin
      r.status = STAT_TOO_LONG;
    end else begin
      probe_table(found, s);
      if (!act) begin
        if (found) r.stamp = tbl_stamp[s];
        else r.status = STAT_NOT_FOUND;
      end else if (!found && (tbl_used * 2 > TABLE_SLOTS || tbl_valid[s])) begin
        r.status = STAT_FULL;
      end else begin
        if (!found) begin
          for (int i = 0; i < NAME_BYTES; i++) tbl_name[s][i] = (i < key_len) ? key_buf[i] : 8'h00;
          tbl_hash[s]  = key_hash;
          tbl_valid[s] = 1'b1;
          tbl_used++;
        end
        if (stamp_ctr != 32'hFFFF_FFFF) stamp_ctr++;
        tbl_stamp[s] = stamp_ctr;
        r.stamp = stamp_ctr;
      end
    end
    lookup_q.push_back(r);
    clear_name_key();
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  initial begin
    err_count     = 0;
    pending_count = 0;
  end

  // Results are compared before the same edge's byte is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_r;
    if (!rst_ni) begin
      clear_name_key();
      for (int s = 0; s < TABLE_SLOTS; s++) tbl_valid[s] = 1'b0;
      tbl_used  = 0;
      stamp_ctr = '0;
      lookup_q.delete();
    end else begin
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result ts=%0d status=%0d",
                                    timestamp_o, status_o));
        end else begin
          exp_r = lookup_q.pop_front();
          if (timestamp_o !== exp_r.stamp)
            report_mismatch($sformatf("timestamp %0d, expected %0d",
                                      timestamp_o, exp_r.stamp));
          if (status_o !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      status_o, exp_r.status));
        end
      end
      if (start && !busy) take_name_byte(action_i, name_byte_i, last_byte_i);
    end
    pending_count = lookup_q.size();
  end

endmodule

// ----- verif/name_timestamp_hash_table_tb.sv -----
// Testbench top for the name timestamp hash table: drives name bytes with random
// gaps, instantiates the block and its checker, and gives the verdict.
// Depends on nth_pkg, name_timestamp_hash_table and name_timestamp_hash_table_checker.
`timescale 1ns / 100ps

module name_timestamp_hash_table_tb;
  import nth_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          POOL_SIZE   = 48;
  localparam int          RAND_BYTES  = 1100;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        action_i;
  logic [7:0]  name_byte_i;
  logic        last_byte_i;
  logic        done_o;
  logic [31:0] timestamp_o;
  logic [1:0]  status_o;
  int unsigned err_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  bit          no_gaps;

  logic [7:0]  name_pool [POOL_SIZE][64];
  int          pool_len  [POOL_SIZE];
  logic [7:0]  cur_name  [64];

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  name_timestamp_hash_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .name_byte_i (name_byte_i),
    .last_byte_i (last_byte_i),
    .done_o      (done_o),
    .timestamp_o (timestamp_o),
    .status_o    (status_o)
  );

  name_timestamp_hash_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .name_byte_i   (name_byte_i),
    .last_byte_i   (last_byte_i),
    .done_o        (done_o),
    .timestamp_o   (timestamp_o),
    .status_o      (status_o),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly back to back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one byte transaction and hold it until busy is low at an edge.
  // Called right after a rising edge; returns after the accepting edge and any idle gap.
  task automatic send_byte(logic act, logic [7:0] b, logic last);
    int gap;
    start       <= 1'b1;
    action_i    <= act;
    name_byte_i <= b;
    last_byte_i <= last;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start       <= 1'b0;
      action_i    <= $urandom_range(0, 1);
      name_byte_i <= $urandom_range(0, 255);
      last_byte_i <= $urandom_range(0, 1);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send cur_name[0..len-1] with the action on the last byte; an empty name is
  // a single zero byte carrying the last flag. Returns the name bytes sent, stray zero bytes not counted.
  task automatic send_name(logic act, int len, int zero_pct, output int sent);
    sent = 0;
    if (len == 0) begin
      send_byte(act, 8'h00, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < zero_pct)
        send_byte($urandom_range(0, 1), 8'h00, 1'b0);
      send_byte((i == len - 1) ? act : logic'($urandom_range(0, 1)), cur_name[i],
                i == len - 1);
      sent++;
    end
  endtask

  // Stop sending until every outstanding lookup has returned.
  // A rising edge is awaited first so the checker has counted the last transaction.
  task automatic drain_lookups();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int total;
    int len;
    int idx;
    cycle_count = 0;
    no_gaps     = 1'b0;
    start       = 1'b0;
    action_i    = 1'b0;
    name_byte_i = 8'h00;
    last_byte_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty name, extreme bytes, ignored zero bytes, long names.
    send_name(1'b0, 0, 0, sent);
    send_name(1'b1, 0, 0, sent);
    send_name(1'b0, 0, 0, sent);
    cur_name[0] = 8'hFF;
    cur_name[1] = 8'h01;
    send_byte(1'b1, 8'hFF, 1'b0);
    send_byte(1'b0, 8'h00, 1'b0);
    send_byte(1'b1, 8'h01, 1'b1);
    send_name(1'b0, 2, 0, sent);
    cur_name[0] = 8'h01;
    cur_name[1] = 8'hFF;
    send_name(1'b0, 2, 0, sent);
    // A zero byte that ends the name still closes it.
    send_byte(1'b0, 8'h7E, 1'b0);
    send_byte(1'b1, 8'h00, 1'b1);
    cur_name[0] = 8'h7E;
    send_name(1'b0, 1, 0, sent);
    for (int i = 0; i < 64; i++) cur_name[i] = 8'h55 ^ i[7:0];
    send_name(1'b1, MAX_NAME, 0, sent);
    send_name(1'b0, MAX_NAME, 0, sent);
    send_name(1'b1, MAX_NAME + 1, 0, sent);
    send_name(1'b0, MAX_NAME + 1, 0, sent);
    cur_name[0] = 8'hFF;
    cur_name[1] = 8'h01;
    send_name(1'b1, 2, 0, sent);
    drain_lookups();

    // Pool of names that recur, so gets hit and the table fills up.
    for (int p = 0; p < POOL_SIZE; p++) begin
      idx = $urandom_range(0, 99);
      if (idx < 4) pool_len[p] = 0;
      else if (idx < 90) pool_len[p] = $urandom_range(1, 8);
      else pool_len[p] = $urandom_range(MAX_NAME - 1, MAX_NAME + 6);
      for (int i = 0; i < 64; i++) name_pool[p][i] = $urandom_range(1, 255);
    end

    // Random: mostly pooled names, some fresh ones, a few with stray zero bytes.
    total = 0;
    while (total < RAND_BYTES) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(0, 99) < 95 ? $urandom_range(0, 10) : $urandom_range(45, 60);
        for (int i = 0; i < 64; i++) cur_name[i] = $urandom_range(1, 255);
      end else begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        len = pool_len[idx];
        for (int i = 0; i < 64; i++) cur_name[i] = name_pool[idx][i];
      end
      send_name($urandom_range(0, 1), len, 5, sent);
      total += (sent == 0) ? 1 : sent;
      if (total > RAND_BYTES / 2 && total - sent <= RAND_BYTES / 2) drain_lookups();
    end

    // Let everything outstanding come back.
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
